FILE: rtl/core/rfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_pkg
// types, constants and the crc byte update shared by the frame deframer
// ----------------------------------------------------------------------------
package rfd_pkg;

   localparam logic [7:0]  HEADER_A  = 8'h90;
   localparam logic [7:0]  HEADER_B  = 8'h40;
   localparam logic [7:0]  FOOTER    = 8'hFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] EV_START  = 16'h0120;
   localparam logic [15:0] EV_END    = 16'h0122;
   localparam logic [15:0] ACK_START = 16'h8120;
   localparam logic [15:0] ACK_END   = 16'h8122;

   typedef enum logic [3:0] {
      PH_HDR0 = 4'd0,
      PH_HDR1 = 4'd1,
      PH_EVT0 = 4'd2,
      PH_EVT1 = 4'd3,
      PH_LEN0 = 4'd4,
      PH_LEN1 = 4'd5,
      PH_DATA = 4'd6,
      PH_CRC0 = 4'd7,
      PH_CRC1 = 4'd8,
      PH_FOOT = 4'd9
   } phase_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] event_code;
      logic [15:0] payload_length;
      logic        frame_status;
      logic        ack_request;
      logic [15:0] ack_code;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/response_frame_deframer_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_frame_deframer_crc16_unit
// byte stream deframer with crc-16 check, one result per good-footer frame
// ----------------------------------------------------------------------------
// path: the byte transfer reaches rsp through the input register, then the
//   phase/crc update into the result register
// throughput: one byte per cycle unless rsp stalls (single byte crc update)
// reset: synchronous; clears both valid flags and returns to header hunting
// ----------------------------------------------------------------------------
module response_frame_deframer_crc16_unit
   import rfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // event_code, payload_length, frame_status,
                                    // ack_request, ack_code, zero pad
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? result.valid : (rsp_valid_ff && !rsp_tready);

   rfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_ff.ack_code, rsp_ff.ack_request,
                        rsp_ff.frame_status, rsp_ff.payload_length, rsp_ff.event_code};

endmodule

FILE: rtl/core/rfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfd_parser
// frame phase tracker with running crc; flags a result on a good footer
// ----------------------------------------------------------------------------
module rfd_parser
   import rfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] event_ff, event_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] crc_next;
   logic [15:0] count_next;
   logic        bad;
   logic        ack;

   assign crc_next   = crc_byte(crc_ff, rx_byte);
   assign count_next = count_ff + 16'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HDR1: begin
            if (rx_byte == HEADER_B) begin
               phase_in = PH_EVT0;
            end else if (rx_byte != HEADER_A) begin
               phase_in = PH_HDR0;
            end
         end
         PH_EVT0: phase_in = PH_EVT1;
         PH_EVT1: phase_in = PH_LEN0;
         PH_LEN0: phase_in = PH_LEN1;
         PH_LEN1: begin
            phase_in = ({rx_byte, length_ff[7:0]} == 16'd0) ? PH_CRC0 : PH_DATA;
         end
         PH_DATA: begin
            if (count_next >= length_ff) begin
               phase_in = PH_CRC0;
            end
         end
         PH_CRC0: phase_in = PH_CRC1;
         PH_CRC1: phase_in = PH_FOOT;
         PH_FOOT: phase_in = PH_HDR0;
         default: phase_in = (rx_byte == HEADER_A) ? PH_HDR1 : PH_HDR0;
      endcase
   end

   // field capture and crc
   always_comb begin
      event_in  = event_ff;
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      unique case (phase_ff)
         PH_HDR1: begin
            if (rx_byte == HEADER_B) begin
               crc_in = CRC_INIT;
            end
         end
         PH_EVT0: begin
            event_in = {8'h00, rx_byte};
            crc_in   = crc_next;
         end
         PH_EVT1: begin
            event_in = {rx_byte, event_ff[7:0]};
            crc_in   = crc_next;
         end
         PH_LEN0: begin
            length_in = {8'h00, rx_byte};
            crc_in    = crc_next;
         end
         PH_LEN1: begin
            length_in = {rx_byte, length_ff[7:0]};
            crc_in    = crc_next;
            count_in  = 16'd0;
         end
         PH_DATA: begin
            crc_in   = crc_next;
            count_in = count_next;
         end
         PH_CRC0: rx_crc_in = {8'h00, rx_byte};
         PH_CRC1: rx_crc_in = {rx_byte, rx_crc_ff[7:0]};
         default: begin
         end
      endcase
   end

   // result
   always_comb begin
      bad = (rx_crc_ff != crc_ff);
      ack = !bad && ((event_ff == EV_START) || (event_ff == EV_END));
      result.valid          = step && (phase_ff == PH_FOOT) && (rx_byte == FOOTER);
      result.event_code     = event_ff;
      result.payload_length = length_ff;
      result.frame_status   = bad;
      result.ack_request    = ack;
      result.ack_code       = ack ? ((event_ff == EV_END) ? ACK_END : ACK_START) : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         event_ff  <= 16'h0000;
         length_ff <= 16'h0000;
         count_ff  <= 16'h0000;
         crc_ff    <= CRC_INIT;
         rx_crc_ff <= 16'h0000;
      end else if (step) begin
         phase_ff  <= phase_in;
         event_ff  <= event_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         rx_crc_ff <= rx_crc_in;
      end
   end

endmodule

FILE: tb/response_frame_deframer_crc16_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_frame_deframer_crc16_unit_test
// drives a serial byte stream into the deframer: a short directed set of
// frames (repeated and broken headers, zero length, ack start and end,
// crc mismatch, bad footer) followed by random well-formed frames mixed with
// noise, broken headers and cut-off frames. each frame result is checked
// field by field against a byte-level parser model kept in the bench, under
// four flow-control phases on both streams.
// ----------------------------------------------------------------------------
module response_frame_deframer_crc16_unit_test
   import rfd_pkg::*;
();

   localparam int RANDOM_BYTES   = 1900;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int DIR_ROWS       = 5;

   typedef struct packed {
      logic [15:0] event_code;
      logic [15:0] payload_length;
      logic        frame_status;
      logic        ack_request;
      logic [15:0] ack_code;
   } frame_result_type;

   typedef struct {
      logic [7:0]       rx_byte;
      bit               fixed_exp;
      bit               fixed_has;
      frame_result_type fixed_res;
   } rx_item_type;

   typedef struct {
      int               nlead;
      logic [7:0]       lead0;
      logic [7:0]       lead1;
      logic [15:0]      ev;
      logic [15:0]      len;
      logic [7:0]       fill;
      bit               bad_crc;
      logic [7:0]       foot;
      bit               fixed_exp;
      bit               fixed_has;
      frame_result_type res;
   } frame_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // rx_byte[7:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [55:0] rsp_tdata;            // event_code, payload_length, frame_status,
                                      // ack_request, ack_code, zero pad

   // repeated header, broken header, ack start/end, crc mismatch, bad footer
   frame_row_type frame_table [DIR_ROWS] = '{
      '{1, HEADER_A, 8'h00, EV_START, 16'd0, 8'h00, 1'b0, FOOTER, 1'b0, 1'b0, '0},
      '{2, HEADER_A, 8'h41, EV_END, 16'd1, 8'hFF, 1'b0, FOOTER, 1'b0, 1'b0, '0},
      '{0, 8'h00, 8'h00, EV_START, 16'd3, 8'h00, 1'b1, FOOTER, 1'b1, 1'b1,
        '{EV_START, 16'd3, 1'b1, 1'b0, 16'h0000}},
      '{1, 8'h7F, 8'h00, 16'hFFFF, 16'd0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, '0},
      '{0, 8'h00, 8'h00, 16'hFFFF, 16'd2, 8'hA5, 1'b0, FOOTER, 1'b0, 1'b0, '0}
   };

   rx_item_type      byte_stream [$];
   frame_result_type pending_frames [$];
   rx_item_type      cur_item;
   frame_result_type got_frame;
   frame_result_type want_frame;
   bit               frame_due;
   frame_result_type frame_pred;
   int               stream_total;
   int               stream_taken = 0;
   int               idle_phase   = 0;
   int               quiet_cycles = 0;
   int               errors       = 0;

   // parser model state
   phase_type   dp_phase  = PH_HDR0;
   logic [15:0] dp_event  = 16'h0000;
   logic [15:0] dp_length = 16'h0000;
   logic [15:0] dp_count  = 16'h0000;
   logic [15:0] dp_crc    = CRC_INIT;
   logic [15:0] dp_rx_crc = 16'h0000;

   response_frame_deframer_crc16_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                     input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, output bit has,
                               output frame_result_type r);
      has = 1'b0;
      r   = '0;
      case (dp_phase)
         PH_HDR1: begin
            if (b == HEADER_B) begin
               dp_crc   = CRC_INIT;
               dp_phase = PH_EVT0;
            end else if (b != HEADER_A) begin
               dp_phase = PH_HDR0;
            end
         end
         PH_EVT0: begin
            dp_event = {8'h00, b};
            dp_crc   = crc16_modbus_byte(dp_crc, b);
            dp_phase = PH_EVT1;
         end
         PH_EVT1: begin
            dp_event = {b, dp_event[7:0]};
            dp_crc   = crc16_modbus_byte(dp_crc, b);
            dp_phase = PH_LEN0;
         end
         PH_LEN0: begin
            dp_length = {8'h00, b};
            dp_crc    = crc16_modbus_byte(dp_crc, b);
            dp_phase  = PH_LEN1;
         end
         PH_LEN1: begin
            dp_length = {b, dp_length[7:0]};
            dp_crc    = crc16_modbus_byte(dp_crc, b);
            dp_count  = 16'h0000;
            dp_phase  = (dp_length == 16'h0000) ? PH_CRC0 : PH_DATA;
         end
         PH_DATA: begin
            dp_crc   = crc16_modbus_byte(dp_crc, b);
            dp_count = dp_count + 16'd1;
            if (dp_count >= dp_length) begin
               dp_phase = PH_CRC0;
            end
         end
         PH_CRC0: begin
            dp_rx_crc = {8'h00, b};
            dp_phase  = PH_CRC1;
         end
         PH_CRC1: begin
            dp_rx_crc = {b, dp_rx_crc[7:0]};
            dp_phase  = PH_FOOT;
         end
         PH_FOOT: begin
            if (b == FOOTER) begin
               has              = 1'b1;
               r.event_code     = dp_event;
               r.payload_length = dp_length;
               r.frame_status   = (dp_rx_crc != dp_crc);
               r.ack_request    = !r.frame_status &&
                                  (dp_event == EV_START || dp_event == EV_END);
               r.ack_code       = !r.ack_request ? 16'h0000 :
                                  (dp_event == EV_END) ? ACK_END : ACK_START;
            end
            dp_phase = PH_HDR0;
         end
         default: begin
            dp_phase = (b == HEADER_A) ? PH_HDR1 : PH_HDR0;
         end
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b);
      byte_stream.push_back('{b, 1'b0, 1'b0, '0});
   endtask

   // fill < 0 gives a random payload
   task automatic add_frame(input logic [15:0] ev, input logic [15:0] len,
                            input int fill, input bit bad_crc,
                            input logic [7:0] foot, input bit fixed_exp,
                            input bit fixed_has, input frame_result_type res);
      logic [15:0] crc;
      logic [7:0]  fields [4];
      logic [7:0]  b;
      fields = '{ev[7:0], ev[15:8], len[7:0], len[15:8]};
      crc    = CRC_INIT;
      push_byte(HEADER_A);
      push_byte(HEADER_B);
      foreach (fields[i]) begin
         crc = crc16_modbus_byte(crc, fields[i]);
         push_byte(fields[i]);
      end
      for (int i = 0; i < int'(len); i++) begin
         b   = (fill < 0) ? 8'($urandom) : 8'(fill);
         crc = crc16_modbus_byte(crc, b);
         push_byte(b);
      end
      if (bad_crc) begin
         crc = crc ^ 16'h8001;
      end
      push_byte(crc[7:0]);
      push_byte(crc[15:8]);
      byte_stream.push_back('{foot, fixed_exp, fixed_has, res});
   endtask

   // byte transfers, prediction and sender idling
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(cur_item.rx_byte, frame_due, frame_pred);
            if (cur_item.fixed_exp) begin
               frame_due  = cur_item.fixed_has;
               frame_pred = cur_item.fixed_res;
            end
            if (frame_due) begin
               pending_frames.push_back(frame_pred);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >=
                ((idle_phase == 1) ? 51 : (idle_phase == 3) ? 10 : 0)) begin
               cur_item = byte_stream.pop_front();
               req_tdata  <= cur_item.rx_byte;
               req_tvalid <= 1'b1;
               stream_taken++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         idle_phase <= (stream_taken * 4) / stream_total;
      end
   end

   // result transfers, checking and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_frame = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[32],
                          rsp_tdata[33], rsp_tdata[49:34]};
            if (pending_frames.size() == 0) begin
               $error("unexpected frame result: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want_frame = pending_frames.pop_front();
               if (got_frame.event_code != want_frame.event_code) begin
                  $error("event_code: expected %h, actual %h",
                         want_frame.event_code, got_frame.event_code);
                  errors++;
               end
               if (got_frame.payload_length != want_frame.payload_length) begin
                  $error("payload_length: expected %h, actual %h",
                         want_frame.payload_length, got_frame.payload_length);
                  errors++;
               end
               if (got_frame.frame_status != want_frame.frame_status) begin
                  $error("frame_status: expected %b, actual %b",
                         want_frame.frame_status, got_frame.frame_status);
                  errors++;
               end
               if (got_frame.ack_request != want_frame.ack_request) begin
                  $error("ack_request: expected %b, actual %b",
                         want_frame.ack_request, got_frame.ack_request);
                  errors++;
               end
               if (got_frame.ack_code != want_frame.ack_code) begin
                  $error("ack_code: expected %h, actual %h",
                         want_frame.ack_code, got_frame.ack_code);
                  errors++;
               end
            end
         end
         rsp_tready <= $urandom_range(99) >=
                       ((idle_phase == 2) ? 51 : (idle_phase == 3) ? 10 : 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int          kind;
      int          v;
      int          dir_bytes;
      logic [15:0] ev;
      logic [15:0] len;
      logic [7:0]  foot;
      foreach (frame_table[i]) begin
         if (frame_table[i].nlead > 0) begin
            push_byte(frame_table[i].lead0);
         end
         if (frame_table[i].nlead > 1) begin
            push_byte(frame_table[i].lead1);
         end
         add_frame(frame_table[i].ev, frame_table[i].len, int'(frame_table[i].fill),
                   frame_table[i].bad_crc, frame_table[i].foot,
                   frame_table[i].fixed_exp, frame_table[i].fixed_has,
                   frame_table[i].res);
      end
      dir_bytes = byte_stream.size();
      while (byte_stream.size() < dir_bytes + RANDOM_BYTES) begin
         kind = $urandom_range(99);
         if (kind < 75) begin
            v  = $urandom_range(99);
            ev = (v < 20) ? EV_START : (v < 40) ? EV_END : (v < 45) ? 16'hFFFF :
                 (v < 50) ? 16'h0000 : 16'($urandom);
            v   = $urandom_range(99);
            len = (v < 25) ? 16'd0 : (v < 80) ? 16'($urandom_range(1, 6)) :
                  (v < 95) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(200, 300));
            foot = ($urandom_range(99) < 8) ? 8'($urandom_range(254)) : FOOTER;
            add_frame(ev, len, -1, $urandom_range(99) < 12, foot, 1'b0, 1'b0, '0);
         end else if (kind < 85) begin
            // noise without the first header byte
            repeat ($urandom_range(1, 4)) begin
               v = $urandom_range(254);
               if (v >= int'(HEADER_A)) begin
                  v++;
               end
               push_byte(8'(v));
            end
         end else if (kind < 92) begin
            // first header byte followed by something else
            v = $urandom_range(253);
            if (v >= int'(HEADER_B)) begin
               v++;
            end
            if (v >= int'(HEADER_A)) begin
               v++;
            end
            push_byte(HEADER_A);
            push_byte(8'(v));
         end else begin
            // frame cut off inside the payload
            push_byte(HEADER_A);
            push_byte(HEADER_B);
            push_byte(8'($urandom));
            push_byte(8'($urandom));
            push_byte(8'($urandom_range(1, 4)));
            push_byte(8'h00);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
         end
      end
      stream_total = byte_stream.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
